@@ hw/rtl/tail_drop_packet_buffer_timing_core_assert.svh @@
// Assertion macros for the packet buffer timing core.
`ifndef TAIL_DROP_PACKET_BUFFER_TIMING_CORE_ASSERT_SVH
`define TAIL_DROP_PACKET_BUFFER_TIMING_CORE_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define TDPB_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define TDPB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TDPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/tdpb_pkg.sv @@
// Package with the constants and types of the packet buffer timing core.
`default_nettype none

package tdpb_pkg;

    localparam int MAX_DEPTH = 64;
    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int TIME_W = 32;
    localparam int CAP_W = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef struct packed {
        logic              occupied;
        logic [TIME_W-1:0] finish;
    } tdpb_entry_t;

    typedef struct packed {
        logic              accept;
        logic              push;
        logic [TIME_W-1:0] arrival;
    } tdpb_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/tdpb_packet_if.sv @@
// Interface for the packet input channel.
`default_nettype none

interface tdpb_packet_if import tdpb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] arrival_tick;
    logic [TIME_W-1:0] service_ticks;

    modport source (output valid, output arrival_tick, output service_ticks, input ready);
    modport sink (input valid, input arrival_tick, input service_ticks, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tdpb_result_if.sv @@
// Interface for the result output channel.
`default_nettype none

interface tdpb_result_if import tdpb_pkg::*;;
    logic              valid;
    logic              ready;
    logic              dropped;
    logic [TIME_W-1:0] begin_tick;

    modport source (output valid, output dropped, output begin_tick, input ready);
    modport sink (input valid, input dropped, input begin_tick, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tdpb_cell.sv @@
// One buffer cell holding a queued finish time and its occupancy.
`default_nettype none

module tdpb_cell import tdpb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire tdpb_ctrl_t  ctrl,
    input  wire tdpb_entry_t upstream,
    output tdpb_entry_t      kept,
    output logic             occupied
);

    logic              occupied_reg;
    logic              occupied_next;
    logic [TIME_W-1:0] finish_reg;

    // An entry retires once its finish time is at or before the arrival.
    always_comb
    begin
        kept.occupied = occupied_reg && (finish_reg > ctrl.arrival);
        kept.finish   = finish_reg;
    end

    always_comb
    begin
        occupied_next = occupied_reg;
        if (ctrl.accept)
        begin
            if (ctrl.push)
            begin
                occupied_next = upstream.occupied;
            end
            else
            begin
                occupied_next = kept.occupied;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg <= 1'b0;
        end
        else
        begin
            occupied_reg <= occupied_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept && ctrl.push)
        begin
            finish_reg <= upstream.finish;
        end
    end

    assign occupied = occupied_reg;

endmodule

`default_nettype wire

@@ hw/rtl/tail_drop_packet_buffer_timing_core.sv @@
// A result is registered when its packet transaction is accepted and is valid in the next cycle.
// Throughput: one packet per cycle while each result is taken; each cell compares its finish time in parallel.
// The output register lets a new packet enter while the last result is being taken.
// Reset clears the cell occupancy, the latest finish time and the result valid,
// and sets the buffer capacity to 64. Queued finish times are not reset.
`default_nettype none

module tail_drop_packet_buffer_timing_core import tdpb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    tdpb_packet_if.sink           packet,
    tdpb_result_if.source         result,
    input  wire logic             cfg_write_en,
    input  wire logic [CAP_W-1:0] cfg_write_data
);

    `include "tail_drop_packet_buffer_timing_core_assert.svh"

    logic [CAP_W-1:0]  cap_reg;
    logic [TIME_W-1:0] latest_reg;
    logic [TIME_W-1:0] latest_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              dropped_reg;
    logic [TIME_W-1:0] start_reg;

    logic              accept;
    logic              full;
    logic              push;
    logic [TIME_W-1:0] raised;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] finish;
    logic [IDX_W-1:0]  cap_idx;
    tdpb_ctrl_t        ctrl;
    tdpb_entry_t       new_entry;
    tdpb_entry_t       kept [MAX_DEPTH];
    tdpb_entry_t       upstream [MAX_DEPTH];
    logic [MAX_DEPTH-1:0] kept_occ;
    logic [MAX_DEPTH-1:0] occ;

    assign packet.ready = !out_valid_reg || result.ready;
    assign accept       = packet.valid && packet.ready;

    always_comb
    begin
        raised = (latest_reg > packet.arrival_tick) ? latest_reg : packet.arrival_tick;
        sum    = {1'b0, raised} + {1'b0, packet.service_ticks};
        finish = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    end

    // Occupancy is a thermometer code, so the buffer is full at zero capacity
    // or when the capacity boundary cell holds an entry after retirement.
    always_comb
    begin
        if (32'(cap_reg) > 32'(MAX_DEPTH))
        begin
            cap_idx = IDX_W'(MAX_DEPTH - 1);
        end
        else
        begin
            cap_idx = IDX_W'(cap_reg - 1'b1);
        end
        full = (cap_reg == '0) || kept_occ[cap_idx];
    end

    assign push = accept && !full;

    always_comb
    begin
        ctrl.accept        = accept;
        ctrl.push          = push;
        ctrl.arrival       = packet.arrival_tick;
        new_entry.occupied = 1'b1;
        new_entry.finish   = finish;
    end

    genvar j;
    generate
        for (j = 0; j < MAX_DEPTH; j++)
        begin : g_cell
            if (j == 0)
            begin : g_head
                assign upstream[j] = new_entry;
            end
            else
            begin : g_body
                assign upstream[j] = kept[j-1];
            end

            tdpb_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .upstream (upstream[j]),
                .kept     (kept[j]),
                .occupied (occ[j])
            );

            assign kept_occ[j] = kept[j].occupied;
        end
    endgenerate

    always_comb
    begin
        latest_next = latest_reg;
        if (accept)
        begin
            latest_next = push ? finish : raised;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            latest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                cap_reg <= cfg_write_data;
            end
            latest_reg    <= latest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dropped_reg <= full;
            start_reg   <= full ? '0 : raised;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.dropped    = dropped_reg;
    assign result.begin_tick = start_reg;

    `TDPB_ASSERT_ALWAYS(a_occ_thermometer, ((occ & (occ + 1'b1)) == '0), "occupancy has a gap")
    `TDPB_ASSERT_NEXT(a_push_fills_head, push, occ[0], "pushed entry missing from head cell")
    `TDPB_ASSERT_SAME(a_drop_start_zero, out_valid_reg && dropped_reg, start_reg == '0,
        "dropped packet has nonzero start time")
    `TDPB_ASSERT_NEXT(a_accept_gives_result, accept, out_valid_reg, "accepted packet gave no result")

endmodule

`default_nettype wire
